// File: hdl/lept_pkg.sv
// ----------------------------------------------------------------------------
// lept_pkg
// Shared constants and types for the line endpoint proximity test.
// ----------------------------------------------------------------------------
package lept_pkg;

    // Default coordinate width
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int RADIUS_W  = 32;
    localparam int WIDTH_W   = 31;
    localparam int HALF_W    = 30;
    localparam int CFG_IDX_W = 3;
    localparam int HIT_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_RADIUS = 3'd6;

    // Load enables for the two register stages of the square unit
    typedef struct packed {
        logic mul;
        logic add;
    } lept_stage_en_t;

endpackage

// File: hdl/lept_sqr.sv
// ----------------------------------------------------------------------------
// lept_sqr
// Two-stage exact squarer: split the operand into halves, register three
// partial products, then register their shifted sum.
// ----------------------------------------------------------------------------
module lept_sqr #(
    parameter int VAL_W = lept_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  lept_pkg::lept_stage_en_t en,
    input  logic [VAL_W-1:0]         val,
    output logic [2*VAL_W-1:0]       sq
);
    import lept_pkg::*;

    localparam int LO_W = (VAL_W + 1) / 2;
    localparam int HI_W = VAL_W - LO_W;
    localparam int SQ_W = 2 * VAL_W;

    logic [LO_W-1:0]      lo;
    logic [HI_W-1:0]      hi;
    logic [2*LO_W-1:0]    pll_reg;
    logic [LO_W+HI_W-1:0] plh_reg;
    logic [2*HI_W-1:0]    phh_reg;
    logic [SQ_W-1:0]      sq_next;
    logic [SQ_W-1:0]      sq_reg;

    assign lo = val[LO_W-1:0];
    assign hi = val[VAL_W-1:LO_W];

    // Register partial products
    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            pll_reg <= (2*LO_W)'(lo) * (2*LO_W)'(lo);
            plh_reg <= (LO_W+HI_W)'(lo) * (LO_W+HI_W)'(hi);
            phh_reg <= (2*HI_W)'(hi) * (2*HI_W)'(hi);
        end
    end

    // Combine: hi^2 << 2L + lo*hi << (L+1) + lo^2
    assign sq_next = (SQ_W'(phh_reg) << (2*LO_W))
                   + (SQ_W'(plh_reg) << (LO_W+1))
                   + SQ_W'(pll_reg);

    always_ff @(posedge clk)
    begin
        if (en.add)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// File: hdl/line_endpoint_proximity_test.sv
// ----------------------------------------------------------------------------
// line_endpoint_proximity_test
// Tests which endpoints of a trace segment attach to a query box or circle.
//
//   Channel  Handshake            Direction  Contents
//   in       in_valid/in_ready    to block   endpoints, width, locked, own_line
//   out      out_valid/out_ready  from block attach_end1, attach_end2, hit_count
//   cfg      cfg_we               to block   cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the depth is set by the
// split squarers of circle mode (distances, products, square, sum, compare).
// Reset clears the configuration registers and all valid bits.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles fill behind a stalled output and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module line_endpoint_proximity_test #(
    parameter int COORD_WIDTH = lept_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [lept_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_WIDTH-1:0]   end1_x,
    input  logic signed [COORD_WIDTH-1:0]   end1_y,
    input  logic signed [COORD_WIDTH-1:0]   end2_x,
    input  logic signed [COORD_WIDTH-1:0]   end2_y,
    input  logic [lept_pkg::WIDTH_W-1:0]    width,
    input  logic                            locked,
    input  logic                            own_line,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            attach_end1,
    output logic                            attach_end2,
    output logic [lept_pkg::HIT_W-1:0]      hit_count
);
    import lept_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int EW   = ((W > 31) ? W : 31) + 2;
    localparam int SW   = (W > 31) ? W : 31;
    localparam int DW   = 2 * W + 1;
    localparam int CW   = (DW > 64) ? DW : 64;
    localparam int NSTG = 5;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] absdiff(logic [W-1:0] a, logic [W-1:0] b);
        logic [W:0] d;
        logic [W:0] m;
        d = {a[W-1], a} - {b[W-1], b};
        m = d[W] ? (~d + 1'b1) : d;
        return m[W-1:0];
    endfunction

    function automatic logic [30:0] sat31(logic [W-1:0] v);
        logic [SW-1:0] e;
        e = SW'(v);
        if (e > SW'(31'h7fff_ffff))
            return 31'h7fff_ffff;
        else
            return e[30:0];
    endfunction

    function automatic logic signed [EW-1:0] sx(logic [W-1:0] v);
        return {{(EW-W){v[W-1]}}, v};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [W-1:0]        box_left_reg, box_bottom_reg, box_right_reg, box_top_reg;
    logic [W-1:0]        centre_x_reg, centre_y_reg;
    logic [RADIUS_W-1:0] query_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg     <= '0;
            box_bottom_reg   <= '0;
            box_right_reg    <= '0;
            box_top_reg      <= '0;
            centre_x_reg     <= '0;
            centre_y_reg     <= '0;
            query_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_LEFT:     box_left_reg     <= cfg_data[W-1:0];
                REG_BOX_BOTTOM:   box_bottom_reg   <= cfg_data[W-1:0];
                REG_BOX_RIGHT:    box_right_reg    <= cfg_data[W-1:0];
                REG_BOX_TOP:      box_top_reg      <= cfg_data[W-1:0];
                REG_CENTRE_X:     centre_x_reg     <= cfg_data[W-1:0];
                REG_CENTRE_Y:     centre_y_reg     <= cfg_data[W-1:0];
                REG_QUERY_RADIUS: query_radius_reg <= cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables and valid bits
    // ------------------------------------------------------------------
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (en[0])
            v_next[0] = in_valid;
        for (int k = 1; k < NSTG; k++)
        begin
            if (en[k])
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 1: edge compares, distances, radius sum
    // ------------------------------------------------------------------
    logic [HALF_W-1:0]     half;
    logic signed [EW-1:0]  r_e;
    logic [W-1:0]          px [2];
    logic [W-1:0]          py [2];
    logic [1:0]            rng_next, inb_next;
    logic [30:0]           bdx_next [2];
    logic [30:0]           bdy_next [2];
    logic [W-1:0]          cdx_next [2];
    logic [W-1:0]          cdy_next [2];
    logic [RADIUS_W-1:0]   s_next;

    assign half  = width[WIDTH_W-1:1];
    assign r_e   = {{(EW-HALF_W){1'b0}}, half};
    assign px[0] = end1_x;
    assign py[0] = end1_y;
    assign px[1] = end2_x;
    assign py[1] = end2_y;
    assign s_next = {1'b0, query_radius_reg[RADIUS_W-2:0]} + {2'b00, half};

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            rng_next[e] = (sx(box_left_reg) - r_e <= sx(px[e]))
                       && (sx(px[e]) <= sx(box_right_reg) + r_e)
                       && (sx(box_bottom_reg) - r_e <= sx(py[e]))
                       && (sx(py[e]) <= sx(box_top_reg) + r_e);
            inb_next[e] = ((sx(box_left_reg) <= sx(px[e]))
                           && (sx(px[e]) <= sx(box_right_reg)))
                       || ((sx(box_bottom_reg) <= sx(py[e]))
                           && (sx(py[e]) <= sx(box_top_reg)));
            bdx_next[e] = sat31((absdiff(box_left_reg, px[e])
                                 < absdiff(box_right_reg, px[e]))
                                ? absdiff(box_left_reg, px[e])
                                : absdiff(box_right_reg, px[e]));
            bdy_next[e] = sat31((absdiff(box_bottom_reg, py[e])
                                 < absdiff(box_top_reg, py[e]))
                                ? absdiff(box_bottom_reg, py[e])
                                : absdiff(box_top_reg, py[e]));
            cdx_next[e] = absdiff(centre_x_reg, px[e]);
            cdy_next[e] = absdiff(centre_y_reg, py[e]);
        end
    end

    logic [1:0]          s1_rng_reg, s1_inb_reg;
    logic [30:0]         s1_bdx_reg [2];
    logic [30:0]         s1_bdy_reg [2];
    logic [W-1:0]        s1_cdx_reg [2];
    logic [W-1:0]        s1_cdy_reg [2];
    logic [HALF_W-1:0]   s1_half_reg;
    logic [RADIUS_W-1:0] s1_s_reg;
    logic                s1_skip_reg, s1_box_reg, s1_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_rng_reg  <= rng_next;
            s1_inb_reg  <= inb_next;
            s1_bdx_reg  <= bdx_next;
            s1_bdy_reg  <= bdy_next;
            s1_cdx_reg  <= cdx_next;
            s1_cdy_reg  <= cdy_next;
            s1_half_reg <= half;
            s1_s_reg    <= s_next;
            s1_skip_reg <= locked || own_line;
            s1_box_reg  <= (query_radius_reg == '0);
            s1_neg_reg  <= query_radius_reg[RADIUS_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: squares (circle squares in the split squarers)
    // ------------------------------------------------------------------
    lept_stage_en_t sq_en;
    logic [2*W-1:0] sqx [2];
    logic [2*W-1:0] sqy [2];

    assign sq_en.mul = en[1];
    assign sq_en.add = en[2];

    for (genvar g = 0; g < 2; g++)
    begin : g_sq
        lept_sqr #(.VAL_W(W)) u_sqx (
            .clk (clk),
            .en  (sq_en),
            .val (s1_cdx_reg[g]),
            .sq  (sqx[g])
        );
        lept_sqr #(.VAL_W(W)) u_sqy (
            .clk (clk),
            .en  (sq_en),
            .val (s1_cdy_reg[g]),
            .sq  (sqy[g])
        );
    end

    logic [1:0]          s2_rng_reg, s2_inb_reg;
    logic [61:0]         s2_bdx2_reg [2];
    logic [61:0]         s2_bdy2_reg [2];
    logic [59:0]         s2_r2_reg;
    logic [63:0]         s2_lim_reg;
    logic                s2_skip_reg, s2_box_reg, s2_neg_reg;

    // Register box squares and the circle limit
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_rng_reg <= s1_rng_reg;
            s2_inb_reg <= s1_inb_reg;
            for (int e = 0; e < 2; e++)
            begin
                s2_bdx2_reg[e] <= 62'(s1_bdx_reg[e]) * 62'(s1_bdx_reg[e]);
                s2_bdy2_reg[e] <= 62'(s1_bdy_reg[e]) * 62'(s1_bdy_reg[e]);
            end
            s2_r2_reg   <= 60'(s1_half_reg) * 60'(s1_half_reg);
            s2_lim_reg  <= 64'(s1_s_reg) * 64'(s1_s_reg);
            s2_skip_reg <= s1_skip_reg;
            s2_box_reg  <= s1_box_reg;
            s2_neg_reg  <= s1_neg_reg;
        end
    end

    logic [1:0]  bh_next;
    logic [1:0]  s3_bh_reg;
    logic [63:0] s3_lim_reg;
    logic        s3_skip_reg, s3_box_reg, s3_neg_reg;

    // Resolve box hits from the corner distance
    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            bh_next[e] = s2_rng_reg[e]
                      && (s2_inb_reg[e]
                          || (({1'b0, s2_bdx2_reg[e]} + {1'b0, s2_bdy2_reg[e]})
                              <= 63'(s2_r2_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_bh_reg   <= bh_next;
            s3_lim_reg  <= s2_lim_reg;
            s3_skip_reg <= s2_skip_reg;
            s3_box_reg  <= s2_box_reg;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squared distances to the centre
    // ------------------------------------------------------------------
    logic [DW-1:0] s4_d_reg [2];
    logic [1:0]    s4_bh_reg;
    logic [63:0]   s4_lim_reg;
    logic          s4_skip_reg, s4_box_reg, s4_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int e = 0; e < 2; e++)
            begin
                s4_d_reg[e] <= {1'b0, sqx[e]} + {1'b0, sqy[e]};
            end
            s4_bh_reg   <= s3_bh_reg;
            s4_lim_reg  <= s3_lim_reg;
            s4_skip_reg <= s3_skip_reg;
            s4_box_reg  <= s3_box_reg;
            s4_neg_reg  <= s3_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the result into the output register
    // ------------------------------------------------------------------
    logic [CW-1:0] lim_eff, d1_c, d2_c;
    logic          a1_next, a2_next;

    assign lim_eff = s4_neg_reg ? '0 : CW'(s4_lim_reg);
    assign d1_c    = CW'(s4_d_reg[0]);
    assign d2_c    = CW'(s4_d_reg[1]);

    always_comb
    begin
        a1_next = 1'b0;
        a2_next = 1'b0;
        if (!s4_skip_reg)
        begin
            if (s4_box_reg)
            begin
                a1_next = s4_bh_reg[0];
                a2_next = s4_bh_reg[1];
            end
            else if ((d1_c <= lim_eff) || (d2_c <= lim_eff))
            begin
                // nearer endpoint wins; a tie goes to the second
                a1_next = (d1_c < d2_c);
                a2_next = !(d1_c < d2_c);
            end
        end
    end

    logic             s5_a1_reg, s5_a2_reg;
    logic [HIT_W-1:0] s5_cnt_reg;
    logic             s5_skip_reg, s5_box_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_a1_reg   <= a1_next;
            s5_a2_reg   <= a2_next;
            s5_cnt_reg  <= {1'b0, a1_next} + {1'b0, a2_next};
            s5_skip_reg <= s4_skip_reg;
            s5_box_reg  <= s4_box_reg;
        end
    end

    assign attach_end1 = s5_a1_reg;
    assign attach_end2 = s5_a2_reg;
    assign hit_count   = s5_cnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skip_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && s5_skip_reg) |-> (hit_count == '0))
        else $error("skipped segment reports a hit");

    a_circle_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !s5_box_reg) |-> !(attach_end1 && attach_end2))
        else $error("circle mode reports both endpoints");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[1] && !en[2]) |=> v_reg[1])
        else $error("stalled item dropped from stage two");

    a_no_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        (!v_reg[NSTG-1] || out_ready) |-> in_ready)
        else $error("input held off while the output is free");

endmodule

// File: tb/lept_attach_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lept_attach_checker
// Watches the configuration port and both item channels of the line endpoint
// proximity test, predicts the attach flags of every accepted segment from a
// private copy of the query registers, and compares each result item in order.
// ----------------------------------------------------------------------------
module lept_attach_checker #(
    parameter int COORD_WIDTH = lept_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lept_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        end1_x,
    input  logic signed [COORD_WIDTH-1:0]        end1_y,
    input  logic signed [COORD_WIDTH-1:0]        end2_x,
    input  logic signed [COORD_WIDTH-1:0]        end2_y,
    input  logic [lept_pkg::WIDTH_W-1:0]         width,
    input  logic                                 locked,
    input  logic                                 own_line,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 attach_end1,
    input  logic                                 attach_end2,
    input  logic [lept_pkg::HIT_W-1:0]           hit_count,
    output int                                   mismatch_count,
    output int                                   attach_pending
);

    import lept_pkg::*;

    typedef longint unsigned ulong_t;

    typedef struct packed {
        logic             end1;
        logic             end2;
        logic [HIT_W-1:0] hits;
    } attach_t;

    // Corner distances past this cannot reach any disc; clamp keeps squares in 64 bits
    localparam ulong_t CORNER_CLAMP = 64'h0000_0000_8000_0000;

    // Shadow of the query registers
    logic signed [COORD_WIDTH-1:0] box_l;
    logic signed [COORD_WIDTH-1:0] box_b;
    logic signed [COORD_WIDTH-1:0] box_r;
    logic signed [COORD_WIDTH-1:0] box_t;
    logic signed [COORD_WIDTH-1:0] ctr_x;
    logic signed [COORD_WIDTH-1:0] ctr_y;
    logic signed [RADIUS_W-1:0]    radius_q;

    // Attach flags of segments accepted but not yet answered, oldest first
    attach_t expected_attach[$];

    function automatic ulong_t span(input longint a, input longint b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Disc of radius r around (px, py) against the box, applied literally
    function automatic logic disc_in_box(input longint px, input longint py, input longint r);
        longint l;
        longint b;
        longint rt;
        longint tp;
        ulong_t dx;
        ulong_t dy;
        ulong_t t;
        l  = box_l;
        b  = box_b;
        rt = box_r;
        tp = box_t;
        if (!(l - r <= px && px <= rt + r && b - r <= py && py <= tp + r))
            return 1'b0;
        if ((l <= px && px <= rt) || (b <= py && py <= tp))
            return 1'b1;
        // nearest corner distance
        dx = span(l, px);
        t  = span(rt, px);
        if (t < dx)
            dx = t;
        dy = span(b, py);
        t  = span(tp, py);
        if (t < dy)
            dy = t;
        if (dx > CORNER_CLAMP)
            dx = CORNER_CLAMP;
        if (dy > CORNER_CLAMP)
            dy = CORNER_CLAMP;
        return (dx * dx + dy * dy) <= ulong_t'(r) * ulong_t'(r);
    endfunction

    function automatic logic [127:0] centre_dist2(input longint px, input longint py);
        logic [127:0] dx;
        logic [127:0] dy;
        dx = span(ctr_x, px);
        dy = span(ctr_y, py);
        return dx * dx + dy * dy;
    endfunction

    function automatic attach_t attach_of(
        input logic signed [COORD_WIDTH-1:0] p1x,
        input logic signed [COORD_WIDTH-1:0] p1y,
        input logic signed [COORD_WIDTH-1:0] p2x,
        input logic signed [COORD_WIDTH-1:0] p2y,
        input logic [WIDTH_W-1:0]            w,
        input logic                          lk,
        input logic                          own
    );
        attach_t      res;
        longint       half;
        longint       rq;
        logic [127:0] reach;
        logic [127:0] s;
        logic [127:0] d1;
        logic [127:0] d2;
        res  = '0;
        half = w >> 1;
        rq   = radius_q;
        // locked and own-line segments never attach
        if (!lk && !own) begin
            if (rq == 0) begin
                res.end1 = disc_in_box(p1x, p1y, half);
                res.end2 = disc_in_box(p2x, p2y, half);
            end
            else begin
                // negative radius: only an exact hit on the centre counts
                if (rq < 0) begin
                    reach = '0;
                end
                else begin
                    s     = rq + half;
                    reach = s * s;
                end
                d1 = centre_dist2(p1x, p1y);
                d2 = centre_dist2(p2x, p2y);
                // report the nearer endpoint only; a tie goes to the second
                if (d1 <= reach || d2 <= reach) begin
                    if (d1 < d2)
                        res.end1 = 1'b1;
                    else
                        res.end2 = 1'b1;
                end
            end
        end
        res.hits = res.end1 + res.end2;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        attach_t want;
        int      bad;
        if (!rst_n) begin
            box_l          <= '0;
            box_b          <= '0;
            box_r          <= '0;
            box_t          <= '0;
            ctr_x          <= '0;
            ctr_y          <= '0;
            radius_q       <= '0;
            mismatch_count <= 0;
            attach_pending <= 0;
        end
        else begin
            bad = 0;
            // track register writes; unknown indexes are dropped
            if (cfg_we) begin
                case (cfg_index)
                    REG_BOX_LEFT:     box_l    <= cfg_data[COORD_WIDTH-1:0];
                    REG_BOX_BOTTOM:   box_b    <= cfg_data[COORD_WIDTH-1:0];
                    REG_BOX_RIGHT:    box_r    <= cfg_data[COORD_WIDTH-1:0];
                    REG_BOX_TOP:      box_t    <= cfg_data[COORD_WIDTH-1:0];
                    REG_CENTRE_X:     ctr_x    <= cfg_data[COORD_WIDTH-1:0];
                    REG_CENTRE_Y:     ctr_y    <= cfg_data[COORD_WIDTH-1:0];
                    REG_QUERY_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest prediction against each result item
            if (out_valid && out_ready) begin
                if (expected_attach.size() == 0) begin
                    $error("result item arrived with no segment outstanding");
                    bad++;
                end
                else begin
                    want = expected_attach.pop_front();
                    if (attach_end1 !== want.end1) begin
                        $error("attach_end1 mismatch: expected %0d, actual %0d",
                               want.end1, attach_end1);
                        bad++;
                    end
                    if (attach_end2 !== want.end2) begin
                        $error("attach_end2 mismatch: expected %0d, actual %0d",
                               want.end2, attach_end2);
                        bad++;
                    end
                    if (hit_count !== want.hits) begin
                        $error("hit_count mismatch: expected %0d, actual %0d",
                               want.hits, hit_count);
                        bad++;
                    end
                end
            end
            // predict each accepted segment with the registers in force now
            if (in_valid && in_ready)
                expected_attach.push_back(attach_of(end1_x, end1_y, end2_x, end2_y,
                                                    width, locked, own_line));
            mismatch_count <= mismatch_count + bad;
            attach_pending <= expected_attach.size();
        end
    end

endmodule

// File: tb/tb_line_endpoint_proximity_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_endpoint_proximity_test
// Streams trace segments through the endpoint proximity test under box,
// inverted box, circle and exact-match queries, with random idle cycles on
// both channels; a side checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_line_endpoint_proximity_test;

    import lept_pkg::*;

    localparam int CW              = COORD_WIDTH_DEF;
    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_PCT        = 37;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int STEADY_PHASE    = 4;

    // Index past the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic signed [31:0]  C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0]  C_MAX = 32'sh7fff_ffff;
    localparam logic [WIDTH_W-1:0]  W_MAX = '1;

    typedef enum int {
        Q_BOX,
        Q_BOX_INVERTED,
        Q_BOX_FULL,
        Q_CIRCLE,
        Q_CIRCLE_WIDE,
        Q_EXACT
    } query_mode_e;

    typedef struct packed {
        logic signed [31:0]   x1;
        logic signed [31:0]   y1;
        logic signed [31:0]   x2;
        logic signed [31:0]   y2;
        logic [WIDTH_W-1:0]   w;
        logic                 lk;
        logic                 own;
    } segment_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [CW-1:0]   end1_x;
    logic signed [CW-1:0]   end1_y;
    logic signed [CW-1:0]   end2_x;
    logic signed [CW-1:0]   end2_y;
    logic [WIDTH_W-1:0]     width;
    logic                   locked;
    logic                   own_line;
    logic                   out_valid;
    logic                   out_ready;
    logic                   attach_end1;
    logic                   attach_end2;
    logic [HIT_W-1:0]       hit_count;
    int                     mismatch_count;
    int                     attach_pending;

    // No idling on either side while set
    logic                   steady;

    // Points around which random endpoints cluster for the current query
    logic signed [31:0]     anchor_x [3];
    logic signed [31:0]     anchor_y [3];

    line_endpoint_proximity_test u_top (.*);

    lept_attach_checker u_check (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: stall at random
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL line_endpoint_proximity_test");
        $finish;
    end

    function automatic segment_t seg(
        input logic signed [31:0] x1,
        input logic signed [31:0] y1,
        input logic signed [31:0] x2,
        input logic signed [31:0] y2,
        input logic [WIDTH_W-1:0] w,
        input logic               lk,
        input logic               own
    );
        segment_t s;
        s.x1  = x1;
        s.y1  = y1;
        s.x2  = x2;
        s.y2  = y2;
        s.w   = w;
        s.lk  = lk;
        s.own = own;
        return s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > C_MAX)
            return C_MAX;
        if (v < C_MIN)
            return C_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] jitter(input logic signed [31:0] base,
                                                  input int unsigned spread);
        longint off;
        off = longint'($urandom_range(2 * spread)) - longint'(spread);
        return clamp32(longint'(base) + off);
    endfunction

    function automatic int unsigned pick_spread();
        case ($urandom_range(3))
            0:       return 1;
            1:       return 15;
            2:       return 1023;
            default: return 1 << 20;
        endcase
    endfunction

    // Random segment near the query, with some wild points and equal ends
    function automatic segment_t make_segment();
        segment_t    s;
        int unsigned spread;
        spread = pick_spread();
        s.x1 = jitter(anchor_x[$urandom_range(2)], spread);
        s.y1 = jitter(anchor_y[$urandom_range(2)], spread);
        s.x2 = jitter(anchor_x[$urandom_range(2)], spread);
        s.y2 = jitter(anchor_y[$urandom_range(2)], spread);
        if ($urandom_range(9) == 0) begin
            s.x1 = $urandom;
            s.y1 = $urandom;
        end
        if ($urandom_range(9) == 0) begin
            s.x2 = $urandom;
            s.y2 = $urandom;
        end
        if ($urandom_range(9) == 0) begin
            s.x2 = s.x1;
            s.y2 = s.y1;
        end
        case ($urandom_range(9))
            0, 1:    s.w = '0;
            2:       s.w = WIDTH_W'($urandom);
            default: s.w = WIDTH_W'($urandom_range(4 * spread));
        endcase
        s.lk  = ($urandom_range(9) == 0);
        s.own = ($urandom_range(9) == 0);
        return s;
    endfunction

    // Present one item; hold it until accepted
    task automatic send_segment(input segment_t s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {end1_x, end1_y, end2_x, end2_y, width, locked, own_line} <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (attach_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write the whole query plus a stray write, then aim the anchors at it
    task automatic load_query(
        input logic signed [31:0] l,
        input logic signed [31:0] b,
        input logic signed [31:0] rt,
        input logic signed [31:0] tp,
        input logic signed [31:0] cx,
        input logic signed [31:0] cy,
        input logic signed [31:0] rad
    );
        write_reg(REG_BOX_LEFT, l);
        write_reg(REG_BOX_BOTTOM, b);
        write_reg(REG_BOX_RIGHT, rt);
        write_reg(REG_BOX_TOP, tp);
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        write_reg(REG_QUERY_RADIUS, rad);
        write_reg(REG_SPARE, $urandom);
        cfg_we <= 1'b0;
        if (rad == 0) begin
            anchor_x[0] = l;
            anchor_x[1] = clamp32((longint'(l) + longint'(rt)) / 2);
            anchor_x[2] = rt;
            anchor_y[0] = b;
            anchor_y[1] = clamp32((longint'(b) + longint'(tp)) / 2);
            anchor_y[2] = tp;
        end
        else if (rad < 0) begin
            anchor_x = '{cx, cx, cx};
            anchor_y = '{cy, cy, cy};
        end
        else begin
            anchor_x[0] = clamp32(longint'(cx) - longint'(rad));
            anchor_x[1] = cx;
            anchor_x[2] = clamp32(longint'(cx) + longint'(rad));
            anchor_y[0] = clamp32(longint'(cy) - longint'(rad));
            anchor_y[1] = cy;
            anchor_y[2] = clamp32(longint'(cy) + longint'(rad));
        end
    endtask

    task automatic random_query(input query_mode_e mode);
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] rad;
        int unsigned        hw;
        int unsigned        hh;
        c_x = $urandom;
        c_y = $urandom;
        if ($urandom_range(1) == 0) begin
            c_x = jitter(0, 1 << 20);
            c_y = jitter(0, 1 << 20);
        end
        hw = pick_spread();
        hh = pick_spread();
        case (mode)
            Q_BOX:
                load_query(clamp32(longint'(c_x) - longint'(hw)),
                           clamp32(longint'(c_y) - longint'(hh)),
                           clamp32(longint'(c_x) + longint'(hw)),
                           clamp32(longint'(c_y) + longint'(hh)),
                           $urandom, $urandom, 0);
            Q_BOX_INVERTED:
                load_query(clamp32(longint'(c_x) + longint'(hw)),
                           clamp32(longint'(c_y) + longint'(hh)),
                           clamp32(longint'(c_x) - longint'(hw)),
                           clamp32(longint'(c_y) - longint'(hh)),
                           $urandom, $urandom, 0);
            Q_BOX_FULL:
                load_query(C_MIN, C_MIN, C_MAX, C_MAX, $urandom, $urandom, 0);
            Q_CIRCLE: begin
                rad = $urandom_range(hw, 1);
                load_query($urandom, $urandom, $urandom, $urandom, c_x, c_y, rad);
            end
            Q_CIRCLE_WIDE: begin
                rad = ($urandom_range(1) == 0) ? C_MAX : $urandom_range(32'h7fff_ffff, 1);
                load_query($urandom, $urandom, $urandom, $urandom, c_x, c_y, rad);
            end
            default: begin
                // any negative radius means exact match
                rad = ($urandom_range(3) == 0) ? {1'b1, 31'($urandom)} : -1;
                load_query($urandom, $urandom, $urandom, $urandom, c_x, c_y, rad);
            end
        endcase
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        steady    <= 1'b0;
        {end1_x, end1_y, end2_x, end2_y, width, locked, own_line} <= '0;
        anchor_x = '{0, 0, 0};
        anchor_y = '{0, 0, 0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset query: box mode on a single point at the origin
        send_segment(seg(0, 0, 0, 0, 0, 0, 0));
        send_segment(seg(C_MAX, C_MAX, C_MIN, C_MIN, W_MAX, 0, 0));
        send_segment(seg(C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, 0));
        send_segment(seg(0, 0, 0, 0, 0, 1, 0));
        send_segment(seg(0, 0, 0, 0, 0, 0, 1));
        send_segment(seg(0, 0, 0, 0, W_MAX, 1, 1));

        // Box mode: inside, corner disc just touching and just missing, edges
        settle();
        load_query(-100, -50, 100, 50, 0, 0, 0);
        send_segment(seg(0, 0, 200, 0, 0, 0, 0));
        send_segment(seg(103, 54, 104, 54, 10, 0, 0));
        send_segment(seg(-105, 0, 0, 55, 11, 0, 0));

        // Inverted box, taken literally
        settle();
        load_query(100, 50, -100, -50, 0, 0, 0);
        send_segment(seg(0, 0, 100, 50, 0, 0, 0));
        send_segment(seg(0, 0, 0, 0, W_MAX, 0, 0));

        // Circle mode: nearer end, tie to the second end, no hit, boundary
        settle();
        load_query(0, 0, 0, 0, 1000, -1000, 50);
        send_segment(seg(1030, -1000, 1000, -960, 0, 0, 0));
        send_segment(seg(1030, -1000, 1000, -970, 0, 0, 0));
        send_segment(seg(2000, 0, -5000, 7, 0, 0, 0));
        send_segment(seg(5000, 5000, 1000, -951, 0, 0, 0));
        send_segment(seg(1051, -1000, 1061, -1000, 2, 0, 0));

        // Exact match with radius -1
        settle();
        load_query(0, 0, 0, 0, 1000, -1000, -1);
        send_segment(seg(1000, -1000, 1001, -1000, W_MAX, 0, 0));
        send_segment(seg(1000, -1000, 1000, -1000, 0, 0, 0));
        send_segment(seg(999, -1000, 1000, -999, 0, 0, 0));

        // Exact match with the most negative radius at a corner of the plane
        settle();
        load_query(0, 0, 0, 0, C_MIN, C_MAX, C_MIN);
        send_segment(seg(C_MIN, C_MAX, 0, 0, 0, 0, 0));
        send_segment(seg(0, 0, C_MIN, C_MAX, 0, 0, 0));

        // Widest circle and widest segment across the whole plane
        settle();
        load_query(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX);
        send_segment(seg(C_MAX, C_MAX, C_MIN, C_MIN, W_MAX, 0, 0));
        send_segment(seg(C_MAX, C_MAX, C_MAX, C_MIN, W_MAX, 0, 0));

        // Full-range box
        settle();
        load_query(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, 0);
        send_segment(seg(C_MAX, C_MIN, C_MIN, C_MAX, W_MAX, 0, 0));
        send_segment(seg(0, 0, C_MAX, C_MAX, 0, 0, 0));

        // Random phases, one query setting each
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            steady <= (p == STEADY_PHASE);
            random_query(query_mode_e'(p % 6));
            repeat (ITEMS_PER_PHASE)
                send_segment(make_segment());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && attach_pending == 0)
            $display("PASS line_endpoint_proximity_test");
        else
            $display("FAIL line_endpoint_proximity_test");
        $finish;
    end

endmodule
